[hw/rtl/pkgd_pkg.sv]
package pkgd_pkg;

  // Gesture event codes carried on the result channel.
  localparam logic [2:0] EV_PRESS     = 3'd0;
  localparam logic [2:0] EV_RELEASE   = 3'd1;
  localparam logic [2:0] EV_LONG      = 3'd2;
  localparam logic [2:0] EV_VERY_LONG = 3'd3;
  localparam logic [2:0] EV_CLICKS    = 3'd4;

  // Hold stage codes.
  localparam logic [1:0] HOLD_NONE      = 2'd0;
  localparam logic [1:0] HOLD_LONG      = 2'd1;
  localparam logic [1:0] HOLD_VERY_LONG = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_TICK_PERIOD = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
  localparam logic [2:0] REG_VERY_LONG   = 3'd2;
  localparam logic [2:0] REG_DOUBLE_CLK  = 3'd3;
  localparam logic [2:0] REG_MAX_CLICKS  = 3'd4;

  // Configuration reset values.
  localparam logic [9:0]  TICK_PERIOD_RESET = 10'd40;
  localparam logic [15:0] LONG_PRESS_RESET  = 16'd1000;
  localparam logic [15:0] VERY_LONG_RESET   = 16'd3000;
  localparam logic [15:0] DOUBLE_CLK_RESET  = 16'd300;
  localparam logic [3:0]  MAX_CLICKS_RESET  = 4'd3;

  localparam logic [15:0] HOLD_TICKS_MAX = 16'hFFFF;
  localparam logic [3:0]  CLICK_RUN_MAX  = 4'hF;

  typedef struct packed {
    logic [9:0]  tick_period_ms;
    logic [15:0] long_press_ms;
    logic [15:0] very_long_press_ms;
    logic [15:0] double_click_ms;
    logic [3:0]  max_clicks;
  } cfg_t;

  typedef struct packed {
    logic        key_down;
    logic [15:0] hold_ticks;
    logic [1:0]  hold_stage;
    logic [3:0]  click_run;
    logic [31:0] last_press_ms;
    logic        check_armed;
  } gesture_state_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] event_res;
    logic [3:0] click_total;
  } step_res_t;

endpackage

[hw/rtl/press_key_gesture_detector_core.sv]
// Flow: an accepted item is held in the input register, and its result, if any, is
// written to the output register once that register is free or being drained.
// Throughput: one item per cycle; the input register refills whenever the result
// register is free or is being drained, and items without a result take no slot.
// Reset (rst, synchronous): configuration returns to its defaults, all gesture
// state clears, and both the input and the output registers are emptied.
module press_key_gesture_detector_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic        s_tuser,   // [0] op
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] click_total, [7:4] zero
  output logic [2:0]  m_tuser    // [2:0] event_res
);
  import pkgd_pkg::*;

  cfg_t           cfg;
  gesture_state_t state;
  gesture_state_t state_next;
  step_res_t      step_res;

  logic        in_valid;
  logic        in_op;
  logic        in_pin;
  logic [31:0] in_now;
  logic        out_valid;
  logic [2:0]  out_event;
  logic [3:0]  out_count;
  logic        advance;

  // The held item is processed once the result register can take its result.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period_ms     <= TICK_PERIOD_RESET;
      cfg.long_press_ms      <= LONG_PRESS_RESET;
      cfg.very_long_press_ms <= VERY_LONG_RESET;
      cfg.double_click_ms    <= DOUBLE_CLK_RESET;
      cfg.max_clicks         <= MAX_CLICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_PERIOD: cfg.tick_period_ms     <= cfg_wdata[9:0];
        REG_LONG_PRESS:  cfg.long_press_ms      <= cfg_wdata;
        REG_VERY_LONG:   cfg.very_long_press_ms <= cfg_wdata;
        REG_DOUBLE_CLK:  cfg.double_click_ms    <= cfg_wdata;
        REG_MAX_CLICKS:  cfg.max_clicks         <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_pin <= s_tdata[0];
      in_now <= s_tdata[32:1];
    end
  end

  pkgd_step u_step (
    .cfg       (cfg),
    .cur       (state),
    .op        (in_op),
    .pin_level (in_pin),
    .now_ms    (in_now),
    .nxt       (state_next),
    .res       (step_res)
  );

  // Gesture state advances once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_res.emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.emit) begin
      out_event <= step_res.event_res;
      out_count <= step_res.click_total;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_event;
  assign m_tdata  = {4'd0, out_count};

  // A tick while the check is disarmed must stay silent.
  a_unarmed_tick_silent: assert property (@(posedge clk) disable iff (rst)
    advance && !in_op && !state.check_armed |-> !step_res.emit)
    else $error("tick produced a result while the check was disarmed");

  // A count is only ever reported with the clicks event.
  a_count_only_clicks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event != EV_CLICKS |-> out_count == 4'd0)
    else $error("nonzero click count on a non-click event");

  // A processed press leaves the key down and the check armed.
  a_press_arms: assert property (@(posedge clk) disable iff (rst)
    advance && in_op && !in_pin |=> state.key_down && state.check_armed)
    else $error("press did not arm the check");

  // The input side stalls only behind a held, undrained result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled without a blocked result");

  // The armed flag tracks an open click run after every tick.
  a_armed_tracks_run: assert property (@(posedge clk) disable iff (rst)
    advance && !in_op && state.check_armed |=>
      state.check_armed == (state.click_run != 4'd0))
    else $error("check armed flag out of step with click run");

endmodule

[hw/rtl/pkgd_step.sv]
module pkgd_step (
  input  pkgd_pkg::cfg_t           cfg,
  input  pkgd_pkg::gesture_state_t cur,
  input  logic                     op,
  input  logic                     pin_level,
  input  logic [31:0]              now_ms,
  output pkgd_pkg::gesture_state_t nxt,
  output pkgd_pkg::step_res_t      res
);
  import pkgd_pkg::*;

  logic [31:0] since_press;
  logic [31:0] since_last;
  logic [15:0] ticks_inc;
  logic [25:0] held;
  logic        in_window;

  // Elapsed time since the recorded press, modulo 2^32.
  assign since_press = now_ms - cur.last_press_ms;
  assign in_window   = since_press <= {16'd0, cfg.double_click_ms};
  assign ticks_inc   = (cur.hold_ticks < HOLD_TICKS_MAX) ? cur.hold_ticks + 16'd1
                                                          : cur.hold_ticks;
  // Hold time in ms; 16 x 10 bits never overflows 26 bits.
  assign held = {10'd0, ticks_inc} * {16'd0, cfg.tick_period_ms};

  // One step of the gesture state machine for a single item.
  always_comb begin
    nxt             = cur;
    res.emit        = 1'b0;
    res.event_res   = EV_PRESS;
    res.click_total = 4'd0;
    since_last      = 32'd0;
    if (op) begin
      res.emit = 1'b1;
      if (!pin_level) begin
        nxt.key_down    = 1'b1;
        nxt.check_armed = 1'b1;
        if (cur.last_press_ms == 32'd0 || in_window) begin
          if (cur.click_run < CLICK_RUN_MAX) begin
            nxt.click_run = cur.click_run + 4'd1;
          end
          nxt.last_press_ms = now_ms;
        end
        res.event_res = EV_PRESS;
      end else begin
        nxt.key_down  = 1'b0;
        res.event_res = EV_RELEASE;
      end
    end else if (cur.check_armed) begin
      nxt.hold_ticks = ticks_inc;
      if (cur.key_down) begin
        if (cur.click_run == 4'd1) begin
          if (held >= {10'd0, cfg.long_press_ms} && cur.hold_stage == HOLD_NONE) begin
            nxt.hold_stage = HOLD_LONG;
            res.emit       = 1'b1;
            res.event_res  = EV_LONG;
          end else if (held >= {10'd0, cfg.very_long_press_ms} &&
                       cur.hold_stage == HOLD_LONG) begin
            nxt.hold_stage = HOLD_VERY_LONG;
            res.emit       = 1'b1;
            res.event_res  = EV_VERY_LONG;
          end
        end
      end else begin
        // A run that ended in a long press is dropped without a report.
        if (cur.hold_stage != HOLD_NONE) begin
          nxt.click_run     = 4'd0;
          nxt.last_press_ms = 32'd0;
        end
        since_last = now_ms - nxt.last_press_ms;
        if (since_last > {16'd0, cfg.double_click_ms} && nxt.click_run != 4'd0) begin
          res.emit        = 1'b1;
          res.event_res   = EV_CLICKS;
          res.click_total = (nxt.click_run > cfg.max_clicks) ? cfg.max_clicks
                                                             : nxt.click_run;
          nxt.click_run     = 4'd0;
          nxt.last_press_ms = 32'd0;
        end
        nxt.hold_ticks = 16'd0;
        nxt.hold_stage = HOLD_NONE;
      end
      nxt.check_armed = nxt.click_run != 4'd0;
    end
  end

endmodule

[tb/press_key_gesture_detector_checker.sv]
package pkgd_tb_pkg;

  // Encodings of the input item fields.
  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_EDGE      = 1'b1;
  localparam logic PIN_PRESSED  = 1'b0;
  localparam logic PIN_RELEASED = 1'b1;

endpackage

module press_key_gesture_detector_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic        s_tuser,   // [0] op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [3:0] click_total, [7:4] zero
  input  logic [2:0]  m_tuser,   // [2:0] event_res
  output int          mismatches,
  output int          pending_events
);
  timeunit 1ns;
  timeprecision 1ps;

  import pkgd_pkg::*;
  import pkgd_tb_pkg::*;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] click_total;
  } gesture_event_t;

  cfg_t           cfg;
  gesture_state_t gs;
  gesture_event_t expected_events[$];
  int             mismatch_count = 0;

  // Counts a mismatch and reports the first few of them.
  task automatic note_mismatch(input string what, input gesture_event_t want,
                               input gesture_event_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("gesture mismatch (%s) at %0t: expected event %0d clicks %0d, got event %0d clicks %0d",
               what, $realtime, want.event_res, want.click_total, got.event_res,
               got.click_total);
  endtask

  // Advances the gesture state by one accepted item and queues the event it causes.
  task automatic apply_gesture_item(input logic op, input logic pin, input logic [31:0] now_ms);
    logic [31:0] held_ms;
    logic [3:0]  clicks;
    if (op == OP_EDGE) begin
      if (pin == PIN_PRESSED) begin
        gs.key_down    = 1'b1;
        gs.check_armed = 1'b1;
        // A press counts when no press is recorded or it falls within the window.
        if (gs.last_press_ms == 32'd0 ||
            (now_ms - gs.last_press_ms) <= {16'd0, cfg.double_click_ms}) begin
          if (gs.click_run != CLICK_RUN_MAX)
            gs.click_run = gs.click_run + 4'd1;
          gs.last_press_ms = now_ms;
        end
        expected_events.push_back(gesture_event_t'{EV_PRESS, 4'd0});
      end else begin
        gs.key_down = 1'b0;
        expected_events.push_back(gesture_event_t'{EV_RELEASE, 4'd0});
      end
    end else if (gs.check_armed) begin
      if (gs.hold_ticks != HOLD_TICKS_MAX)
        gs.hold_ticks = gs.hold_ticks + 16'd1;
      if (gs.key_down) begin
        // Hold time in ms, kept to 32 bits.
        held_ms = {16'd0, gs.hold_ticks} * {22'd0, cfg.tick_period_ms};
        if (gs.click_run == 4'd1) begin
          if (held_ms >= {16'd0, cfg.long_press_ms} && gs.hold_stage == HOLD_NONE) begin
            gs.hold_stage = HOLD_LONG;
            expected_events.push_back(gesture_event_t'{EV_LONG, 4'd0});
          end else if (held_ms >= {16'd0, cfg.very_long_press_ms} &&
                       gs.hold_stage == HOLD_LONG) begin
            gs.hold_stage = HOLD_VERY_LONG;
            expected_events.push_back(gesture_event_t'{EV_VERY_LONG, 4'd0});
          end
        end
      end else begin
        // A run that ended in a long press is dropped silently.
        if (gs.hold_stage != HOLD_NONE) begin
          gs.click_run     = 4'd0;
          gs.last_press_ms = 32'd0;
        end
        if ((now_ms - gs.last_press_ms) > {16'd0, cfg.double_click_ms} &&
            gs.click_run != 4'd0) begin
          clicks = (gs.click_run > cfg.max_clicks) ? cfg.max_clicks : gs.click_run;
          expected_events.push_back(gesture_event_t'{EV_CLICKS, clicks});
          gs.click_run     = 4'd0;
          gs.last_press_ms = 32'd0;
        end
        gs.hold_ticks = 16'd0;
        gs.hold_stage = HOLD_NONE;
      end
      gs.check_armed = (gs.click_run != 4'd0);
    end
  endtask

  // Watches the configuration port and both streams at every rising edge.
  always @(posedge clk) begin
    gesture_event_t want;
    gesture_event_t got;
    if (rst) begin
      cfg = '{TICK_PERIOD_RESET, LONG_PRESS_RESET, VERY_LONG_RESET, DOUBLE_CLK_RESET,
              MAX_CLICKS_RESET};
      gs  = '0;
      expected_events.delete();
    end else begin
      // Compare the result transfer with the oldest queued event.
      if (m_tvalid && m_tready) begin
        got = gesture_event_t'{m_tuser, m_tdata[3:0]};
        if (expected_events.size() == 0) begin
          want = '0;
          note_mismatch("no event pending", want, got);
        end else begin
          want = expected_events.pop_front();
          if (got.event_res !== want.event_res || got.click_total !== want.click_total)
            note_mismatch("wrong field", want, got);
        end
      end

      // Register writes land in the local copy of the configuration.
      if (cfg_we) begin
        case (cfg_index)
          REG_TICK_PERIOD: cfg.tick_period_ms     = cfg_wdata[9:0];
          REG_LONG_PRESS:  cfg.long_press_ms      = cfg_wdata;
          REG_VERY_LONG:   cfg.very_long_press_ms = cfg_wdata;
          REG_DOUBLE_CLK:  cfg.double_click_ms    = cfg_wdata;
          REG_MAX_CLICKS:  cfg.max_clicks         = cfg_wdata[3:0];
          default: ;
        endcase
      end

      // Every input transfer steps the gesture state.
      if (s_tvalid && s_tready)
        apply_gesture_item(s_tuser, s_tdata[0], s_tdata[32:1]);
    end
    mismatches     <= mismatch_count;
    pending_events <= expected_events.size();
  end

endmodule

[tb/tb_press_key_gesture_detector_core.sv]
module tb_press_key_gesture_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pkgd_pkg::*;
  import pkgd_tb_pkg::*;

  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int PHASE_ITEMS    = 120;
  localparam int SETTLE_CYCLES  = 6;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;

  int          mismatches;
  int          pending_events;
  int          cycle_count = 0;

  // Stimulus state: the current time and the settings in force.
  logic [31:0] now_ms;
  bit          no_gaps;
  int          sent_items;
  int          cur_period;
  int          cur_long;
  int          cur_very;
  int          cur_dbl;
  int          cur_max;

  press_key_gesture_detector_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  press_key_gesture_detector_checker gesture_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatches     (mismatches),
    .pending_events (pending_events)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one item and waits for its transfer.
  task automatic send_item(input logic op, input logic pin, input logic [31:0] t);
    int gap;
    gap = no_gaps ? 0 : pick_idle();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, t, pin};
    do @(posedge clk); while (!s_tready);
    sent_items++;
  endtask

  // Stops the input and waits until every expected event has arrived.
  task automatic drain_and_settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_events != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[15:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input int period, input int long_ms, input int very_ms,
                            input int dbl_ms, input int max_cnt);
    write_reg(REG_TICK_PERIOD, period);
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_VERY_LONG, very_ms);
    write_reg(REG_DOUBLE_CLK, dbl_ms);
    write_reg(REG_MAX_CLICKS, max_cnt);
    cur_period = period;
    cur_long   = long_ms;
    cur_very   = very_ms;
    cur_dbl    = dbl_ms;
    cur_max    = max_cnt;
  endtask

  // A run of short clicks, closed by ticks once the window has passed.
  task automatic click_sequence(input int presses);
    for (int i = 0; i < presses; i++) begin
      send_item(OP_EDGE, PIN_PRESSED, now_ms);
      repeat ($urandom_range(0, 2))
        send_item(OP_TICK, $urandom_range(0, 1), now_ms);
      now_ms += $urandom_range(0, cur_dbl / 4);
      send_item(OP_EDGE, PIN_RELEASED, now_ms);
      // Mostly stay inside the window, now and then miss it.
      if ($urandom_range(0, 9) == 0)
        now_ms += cur_dbl + $urandom_range(1, 100);
      else
        now_ms += $urandom_range(0, cur_dbl / 2);
      if ($urandom_range(0, 3) == 0)
        send_item(OP_TICK, $urandom_range(0, 1), now_ms);
    end
    repeat ($urandom_range(0, 2)) begin
      now_ms += $urandom_range(0, cur_dbl / 3);
      send_item(OP_TICK, $urandom_range(0, 1), now_ms);
    end
    now_ms += cur_dbl + $urandom_range(1, 200);
    send_item(OP_TICK, $urandom_range(0, 1), now_ms);
  endtask

  // A single press held long enough to pass both thresholds, or cut short.
  task automatic hold_sequence();
    int n;
    n = (cur_period == 0) ? 3 : cur_very / cur_period + 2 + $urandom_range(0, 2);
    if (n > 48)
      n = 48;
    if ($urandom_range(0, 3) == 0)
      n = $urandom_range(1, n);
    send_item(OP_EDGE, PIN_PRESSED, now_ms);
    repeat (n) begin
      now_ms += cur_period;
      send_item(OP_TICK, $urandom_range(0, 1), now_ms);
    end
    now_ms += $urandom_range(1, 50);
    send_item(OP_EDGE, PIN_RELEASED, now_ms);
    now_ms += cur_dbl + $urandom_range(1, 100);
    send_item(OP_TICK, $urandom_range(0, 1), now_ms);
  endtask

  // Edges and ticks in any order with small time steps.
  task automatic broken_sequence();
    repeat ($urandom_range(2, 8)) begin
      now_ms += $urandom_range(0, cur_dbl + 10);
      send_item($urandom_range(0, 1), $urandom_range(0, 1), now_ms);
    end
  endtask

  // Fully random items, time included.
  task automatic noise_items();
    repeat ($urandom_range(1, 6))
      send_item($urandom_range(0, 1), $urandom_range(0, 1), $urandom());
  endtask

  // One phase of mixed gesture traffic under the current settings.
  task automatic run_phase();
    int start;
    int r;
    start = sent_items;
    while (sent_items - start < PHASE_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0)
        now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      r = $urandom_range(0, 99);
      if (r < 45)
        click_sequence(($urandom_range(0, 7) == 0) ? $urandom_range(5, 17)
                                                   : $urandom_range(1, 4));
      else if (r < 70)
        hold_sequence();
      else if (r < 85)
        broken_sequence();
      else
        noise_items();
    end
    no_gaps = 1'b0;
  endtask

  task automatic random_config();
    int p;
    int lp;
    int vl;
    int dbl;
    case ($urandom_range(0, 9))
      0: p = $urandom_range(0, 1023);
      1: p = 1000;
      default: p = $urandom_range(1, 100);
    endcase
    lp = p * $urandom_range(0, 10);
    vl = lp + p * $urandom_range(0, 10);
    if ($urandom_range(0, 7) == 0)
      vl = $urandom_range(0, lp);
    if ($urandom_range(0, 9) == 0)
      lp = $urandom_range(0, 65535);
    if (lp > 65535)
      lp = 65535;
    if (vl > 65535)
      vl = 65535;
    case ($urandom_range(0, 9))
      0: dbl = 0;
      1: dbl = 65535;
      2: dbl = $urandom_range(0, 65535);
      default: dbl = $urandom_range(20, 1500);
    endcase
    set_config(p, lp, vl, dbl, $urandom_range(0, 15));
  endtask

  // Result side: ready with random stalls and stretches without any.
  initial begin
    int stall;
    int run_len;
    m_tready = 1'b0;
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        @(negedge clk);
        m_tready <= 1'b1;
        repeat ($urandom_range(20, 100)) @(negedge clk);
      end else begin
        run_len = $urandom_range(1, 6);
        stall   = pick_idle();
        @(negedge clk);
        m_tready <= 1'b1;
        repeat (run_len - 1) @(negedge clk);
        if (stall > 0) begin
          @(negedge clk);
          m_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_TICK_PERIOD;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tuser    = OP_TICK;
    s_tdata    = '0;
    now_ms     = '0;
    no_gaps    = 1'b0;
    sent_items = 0;
    cur_period = TICK_PERIOD_RESET;
    cur_long   = LONG_PRESS_RESET;
    cur_very   = VERY_LONG_RESET;
    cur_dbl    = DOUBLE_CLK_RESET;
    cur_max    = MAX_CLICKS_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings.
    // A tick before anything is armed is ignored.
    send_item(OP_TICK, PIN_RELEASED, 32'd0);
    // A press at time zero leaves no press recorded, so the next one joins the same run.
    send_item(OP_EDGE, PIN_PRESSED, 32'd0);
    send_item(OP_EDGE, PIN_RELEASED, 32'd10);
    send_item(OP_EDGE, PIN_PRESSED, 32'd5000);
    send_item(OP_EDGE, PIN_RELEASED, 32'd5050);
    send_item(OP_TICK, PIN_PRESSED, 32'd5100);
    send_item(OP_TICK, PIN_RELEASED, 32'd5301);
    // A run across the time wrap, clamped to the maximum count.
    send_item(OP_EDGE, PIN_PRESSED, 32'hFFFF_FFF0);
    send_item(OP_EDGE, PIN_RELEASED, 32'hFFFF_FFF8);
    send_item(OP_EDGE, PIN_PRESSED, 32'h0000_0010);
    send_item(OP_EDGE, PIN_RELEASED, 32'h0000_0020);
    send_item(OP_EDGE, PIN_PRESSED, 32'h0000_0100);
    send_item(OP_EDGE, PIN_RELEASED, 32'h0000_0110);
    send_item(OP_EDGE, PIN_PRESSED, 32'h0000_0200);
    send_item(OP_EDGE, PIN_RELEASED, 32'h0000_0210);
    send_item(OP_TICK, PIN_RELEASED, 32'h0000_032D);
    // A press outside the window is reported but not counted.
    send_item(OP_EDGE, PIN_PRESSED, 32'd1000);
    send_item(OP_EDGE, PIN_RELEASED, 32'd1100);
    send_item(OP_EDGE, PIN_PRESSED, 32'd2000);
    send_item(OP_EDGE, PIN_RELEASED, 32'd2100);
    send_item(OP_TICK, PIN_RELEASED, 32'd2500);
    drain_and_settle();

    // Extreme settings, starting with zero period, zero thresholds, no window, zero clicks.
    now_ms = 32'd7000;
    set_config(0, 0, 0, 0, 0);
    run_phase();
    drain_and_settle();
    set_config(1, 0, 0, 0, 1);
    run_phase();
    drain_and_settle();
    set_config(1000, 65535, 65535, 65535, 15);
    run_phase();
    drain_and_settle();
    set_config(1023, 1023, 2046, 300, 15);
    run_phase();
    drain_and_settle();

    // Random part, one setting per phase.
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      random_config();
      run_phase();
      drain_and_settle();
    end

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pkgd_pkg.sv
hw/rtl/pkgd_step.sv
hw/rtl/press_key_gesture_detector_core.sv
tb/press_key_gesture_detector_checker.sv
tb/tb_press_key_gesture_detector_core.sv
